// ===== design/planar_odometry_integrator_core_macros.svh =====
// assertion macros used by the odometry integrator control module
`ifndef PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH
`define PLANAR_ODOMETRY_INTEGRATOR_CORE_MACROS_SVH

// same-cycle implication, checked on every rising edge out of reset
`define POI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define POI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/poi_pkg.sv =====
// shared constants, tables and control types of the odometry integrator
package poi_pkg;

  localparam int CORDIC_STEPS = 16;
  localparam int POS_WIDTH    = 32;

  localparam int ITER_W       = $clog2(CORDIC_STEPS);
  localparam int ATAN_ENTRIES = 24;
  localparam int ATAN_IDX_W   = $clog2(ATAN_ENTRIES);

  // rounded position step is at most 25 bits wide
  localparam int STEP_W = 25;
  localparam int SUM_W  = ((POS_WIDTH > STEP_W) ? POS_WIDTH : STEP_W) + 1;

  localparam logic signed [31:0] GAIN_Q30       = 32'sd652032874;
  localparam logic signed [31:0] TURN_SCALE_Q16 = 32'sd683565276;

  // atan(2^-i) with a full turn equal to 2^32
  localparam logic [29:0] ATAN_TURN32 [ATAN_ENTRIES] = '{
    30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756, 30'd42667331,
    30'd21354465, 30'd10679838, 30'd5340245, 30'd2670163, 30'd1335087,
    30'd667544, 30'd333772, 30'd166886, 30'd83443, 30'd41722,
    30'd20861, 30'd10430, 30'd5215, 30'd2608, 30'd1304,
    30'd652, 30'd326, 30'd163, 30'd81
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROT,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_H,
    ST_FIN
  } poi_state_t;

  typedef enum logic [1:0] {
    MS_COS,
    MS_SIN,
    MS_TURN
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     rot;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     acc_x;
    logic     acc_y;
    logic     fin;
  } poi_cmd_t;

  typedef struct packed {
    logic rot_done;
  } poi_stat_t;

endpackage

// ===== design/poi_ctrl.sv =====
// sequencing state machine of the odometry integrator
`include "planar_odometry_integrator_core_macros.svh"

module poi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  poi_pkg::poi_stat_t stat,
  output poi_pkg::poi_cmd_t  cmd
);
  import poi_pkg::*;

  poi_state_t state, state_next;
  logic       out_free;

  assign out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.fin) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next  = state;
    s_tready    = 1'b0;
    cmd         = '0;
    cmd.mul_sel = MS_COS;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = ST_ROT;
        end
      end
      ST_ROT: begin
        cmd.rot = 1'b1;
        if (stat.rot_done) begin
          state_next = ST_MUL_X;
        end
      end
      ST_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_COS;
        state_next  = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_SIN;
        cmd.acc_x   = 1'b1;
        state_next  = ST_MUL_H;
      end
      ST_MUL_H: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MS_TURN;
        cmd.acc_y   = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: begin
        // heading update and result load wait for a free output register
        if (out_free) begin
          cmd.fin    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `POI_ASSERT_NXT(a_accept_starts_rot, s_tvalid && s_tready, state == ST_ROT, "accepted item did not start rotation")
  `POI_ASSERT_IMP(a_mulx_after_rot, state == ST_MUL_X, $past(state == ST_ROT && stat.rot_done), "products started before rotation finished")
  `POI_ASSERT_NXT(a_fin_sets_valid, cmd.fin, m_tvalid, "finished item not presented")
  `POI_ASSERT_IMP(a_fin_holds_stalled, state == ST_FIN && m_tvalid && !m_tready, !cmd.fin, "pose update ran over a stalled result")

endmodule

// ===== design/poi_datapath.sv =====
// cordic rotator, shared multiplier, pose registers and result register
module poi_datapath (
  input  logic               clk,
  input  logic               rst,
  input  logic [47:0]        s_tdata,
  input  poi_pkg::poi_cmd_t  cmd,
  output poi_pkg::poi_stat_t stat,
  output logic [79:0]        m_tdata,
  output logic               m_tuser
);
  import poi_pkg::*;

  logic signed [15:0] in_v;
  logic signed [15:0] in_w;
  logic        [15:0] in_dt;
  logic signed [32:0] vdt_full;
  logic signed [32:0] wdt_full;

  logic signed [31:0] vdt;
  logic signed [31:0] wdt;
  logic               moving;

  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [33:0] cz;
  logic               flip;
  logic [ITER_W-1:0]  iter;

  logic signed [15:0] yaw_s;
  logic signed [17:0] a_ext;
  logic signed [17:0] a_fold;
  logic               flip_next;
  logic        [29:0] atan_val;

  logic signed [31:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [63:0] prod;
  logic signed [63:0] prod_next;

  logic signed [POS_WIDTH-1:0] pose_x;
  logic signed [POS_WIDTH-1:0] pose_y;
  logic        [15:0]          yaw;

  logic signed [STEP_W-1:0]    step;
  logic signed [SUM_W-1:0]     sum_x;
  logic signed [SUM_W-1:0]     sum_y;
  logic signed [POS_WIDTH-1:0] pose_x_next;
  logic signed [POS_WIDTH-1:0] pose_y_next;
  logic        [15:0]          yaw_next;
  logic signed [63:0]          pose_x_ext;
  logic signed [63:0]          pose_y_ext;

  localparam logic signed [SUM_W-1:0] POS_MAX =
    SUM_W'((65'sd1 <<< (POS_WIDTH - 1)) - 65'sd1);
  localparam logic signed [SUM_W-1:0] POS_MIN = -POS_MAX - SUM_W'(1);

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(logic signed [SUM_W-1:0] s);
    logic signed [POS_WIDTH-1:0] r;
    if (s > POS_MAX) begin
      r = POS_MAX[POS_WIDTH-1:0];
    end else if (s < POS_MIN) begin
      r = POS_MIN[POS_WIDTH-1:0];
    end else begin
      r = s[POS_WIDTH-1:0];
    end
    return r;
  endfunction

  // input item: linear_velocity, turn_rate, elapsed_time
  assign in_v     = s_tdata[15:0];
  assign in_w     = s_tdata[31:16];
  assign in_dt    = s_tdata[47:32];
  assign vdt_full = in_v * $signed({1'b0, in_dt});
  assign wdt_full = in_w * $signed({1'b0, in_dt});

  // fold the heading into a quarter turn either side of zero
  assign yaw_s = yaw;
  assign a_ext = 18'(yaw_s);
  always_comb begin
    a_fold    = a_ext;
    flip_next = 1'b0;
    if (a_ext > 18'sd16384) begin
      a_fold    = a_ext - 18'sd32768;
      flip_next = 1'b1;
    end else if (a_ext < -18'sd16384) begin
      a_fold    = a_ext + 18'sd32768;
      flip_next = 1'b1;
    end
  end

  assign atan_val      = ATAN_TURN32[ATAN_IDX_W'(iter)];
  assign stat.rot_done = (iter == ITER_W'(CORDIC_STEPS - 1));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      vdt    <= vdt_full[31:0];
      wdt    <= wdt_full[31:0];
      moving <= (in_v != 16'sd0) || (in_w != 16'sd0);
      cx     <= GAIN_Q30;
      cy     <= 32'sd0;
      cz     <= {a_fold, 16'b0};
      flip   <= flip_next;
      iter   <= '0;
    end else if (cmd.rot) begin
      if (!cz[33]) begin
        cx <= cx - (cy >>> iter);
        cy <= cy + (cx >>> iter);
        cz <= cz - 34'(atan_val);
      end else begin
        cx <= cx + (cy >>> iter);
        cy <= cy - (cx >>> iter);
        cz <= cz + 34'(atan_val);
      end
      iter <= iter + ITER_W'(1);
    end
  end

  // one shared multiplier, operands picked per step
  always_comb begin
    unique case (cmd.mul_sel)
      MS_COS: begin
        mul_a = vdt;
        mul_b = flip ? -cx : cx;
      end
      MS_SIN: begin
        mul_a = vdt;
        mul_b = flip ? -cy : cy;
      end
      MS_TURN: begin
        mul_a = wdt;
        mul_b = TURN_SCALE_Q16;
      end
      default: begin
        mul_a = vdt;
        mul_b = cx;
      end
    endcase
  end

  assign prod_next = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
  end

  // round half up: floor of the shifted product plus the first dropped bit
  assign step  = STEP_W'($signed(prod[63:40])) + STEP_W'({1'b0, prod[39]});
  assign sum_x = SUM_W'(pose_x) + SUM_W'(step);
  assign sum_y = SUM_W'(pose_y) + SUM_W'(step);
  assign pose_x_next = sat_pos(sum_x);
  assign pose_y_next = sat_pos(sum_y);
  assign yaw_next    = yaw + prod[59:44] + 16'(prod[43]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pose_x <= '0;
      pose_y <= '0;
      yaw    <= '0;
    end else begin
      if (cmd.acc_x) begin
        pose_x <= pose_x_next;
      end
      if (cmd.acc_y) begin
        pose_y <= pose_y_next;
      end
      if (cmd.fin) begin
        yaw <= yaw_next;
      end
    end
  end

  assign pose_x_ext = 64'(pose_x);
  assign pose_y_ext = 64'(pose_y);

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      m_tdata <= {yaw_next, pose_y_ext[31:0], pose_x_ext[31:0]};
      m_tuser <= moving;
    end
  end

endmodule

// ===== design/planar_odometry_integrator_core.sv =====
// planar odometry integrator: one pose result per speed, turn rate and time item
// steps per item: load, cordic rotation, cos, sin and turn products, then finish
// items are taken one at a time, only while idle; the pace is set by the iterative cordic rotator
//   (one micro-rotation per cycle) and three passes through one shared multiplier
// a finished result waits in the output register while the next item is accepted
// reset (rst, synchronous) clears x, y and heading to zero and drops m_tvalid
module planar_odometry_integrator_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // linear_velocity, turn_rate, elapsed_time
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // position_x, position_y, heading
  output logic        m_tuser    // moving
);
  import poi_pkg::*;

  poi_cmd_t  cmd;
  poi_stat_t stat;

  poi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  poi_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .cmd     (cmd),
    .stat    (stat),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
